>>> design/polygon_sat_collision_unit_assert.svh
// Assertion macros used by the checker file of the collision unit.
`ifndef POLYGON_SAT_COLLISION_UNIT_ASSERT_SVH
`define POLYGON_SAT_COLLISION_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SAT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sat checker: same-cycle implication failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SAT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sat checker: next-cycle implication failed");

`endif

>>> design/sat_pkg.sv
// Package of the SAT collision unit: payload types, control structs, constants.
package sat_pkg;

    localparam int SAT_COORD_BITS   = 24;
    localparam int SAT_MAX_VERTICES = 16;
    localparam int SAT_NORM_BITS    = 16;
    localparam int SAT_SQRT_STEPS   = 21;
    localparam int SAT_DIV_STEPS    = 36;
    localparam int SAT_DRAIN        = 2;
    localparam int SAT_STEP_BITS    = 6;

    typedef struct packed {
        logic                             which_polygon;
        logic signed [SAT_COORD_BITS-1:0] vertex_x;
        logic signed [SAT_COORD_BITS-1:0] vertex_y;
        logic                             last_vertex;
    } sat_in_t;

    typedef struct packed {
        logic                             collides;
        logic signed [SAT_COORD_BITS-1:0] push_x;
        logic signed [SAT_COORD_BITS-1:0] push_y;
    } sat_out_t;

    typedef struct packed {
        logic signed [SAT_COORD_BITS-1:0] x;
        logic signed [SAT_COORD_BITS-1:0] y;
    } sat_vtx_t;

    typedef struct packed {
        logic load;
        logic test_clear;
        logic pass_init;
        logic pass_b;
        logic edge_rd1;
        logic edge_rd2;
        logic edge_load;
        logic norm_step;
        logic zero_normal;
        logic square;
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic div_done;
        logic proj_start;
        logic proj_rd;
        logic check;
        logic save_pass;
        logic push_sel;
        logic push_lo;
        logic push_hi;
        logic push_round;
        logic push_comp;
        logic out_fire;
        logic out_apart;
    } sat_cmd_t;

    typedef struct packed {
        logic a_empty;
        logic edge_zero;
        logic norm_ok;
        logic proj_last;
        logic separated;
        logic edge_last;
    } sat_stat_t;

endpackage

>>> design/sat_ctrl.sv
// Sequencer of the SAT collision unit: walks edges, passes and push steps.
module sat_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             which_polygon,
    input  logic             last_vertex,
    input  sat_pkg::sat_stat_t stat,
    output sat_pkg::sat_cmd_t  cmd,
    output logic             busy
);
    import sat_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_TEST, S_RD1, S_RD2, S_EDGE, S_NORM, S_SQ, S_SQI, S_SQRT,
        S_DIVI, S_DIV, S_NRM, S_PROJ0, S_PROJ, S_DRAIN, S_CHECK, S_PASSB,
        S_SEL, S_MLO, S_MHI, S_RND, S_OUT, S_APART
    } state_t;

    state_t                   state_reg, state_next;
    logic                     pass_reg, pass_next;
    logic                     comp_reg, comp_next;
    logic [SAT_STEP_BITS-1:0] cnt_reg, cnt_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd           = '0;
        cmd.pass_b    = pass_reg;
        cmd.push_comp = comp_reg;
        state_next    = state_reg;
        pass_next     = pass_reg;
        comp_next     = comp_reg;
        cnt_next      = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (which_polygon && last_vertex)
                        state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (stat.a_empty)
                    state_next = S_APART;
                else
                begin
                    cmd.pass_init = 1'b1;
                    pass_next     = 1'b0;
                    state_next    = S_RD1;
                end
            end
            S_RD1:
            begin
                cmd.edge_rd1 = 1'b1;
                state_next   = S_RD2;
            end
            S_RD2:
            begin
                cmd.edge_rd2 = 1'b1;
                state_next   = S_EDGE;
            end
            S_EDGE:
            begin
                cmd.edge_load = 1'b1;
                state_next    = S_NORM;
            end
            S_NORM:
            begin
                if (stat.edge_zero)
                begin
                    cmd.zero_normal = 1'b1;
                    state_next      = S_PROJ0;
                end
                else if (stat.norm_ok)
                    state_next = S_SQ;
                else
                    cmd.norm_step = 1'b1;
            end
            S_SQ:
            begin
                cmd.square = 1'b1;
                state_next = S_SQI;
            end
            S_SQI:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == SAT_STEP_BITS'(SAT_SQRT_STEPS - 1))
                    state_next = S_DIVI;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == SAT_STEP_BITS'(SAT_DIV_STEPS - 1))
                    state_next = S_NRM;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_NRM:
            begin
                cmd.div_done = 1'b1;
                state_next   = S_PROJ0;
            end
            S_PROJ0:
            begin
                cmd.proj_start = 1'b1;
                state_next     = S_PROJ;
            end
            S_PROJ:
            begin
                cmd.proj_rd = 1'b1;
                if (stat.proj_last)
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (cnt_reg == SAT_STEP_BITS'(SAT_DRAIN - 1))
                    state_next = S_CHECK;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_CHECK:
            begin
                if (stat.separated)
                    state_next = S_APART;
                else
                begin
                    cmd.check = 1'b1;
                    if (!stat.edge_last)
                        state_next = S_RD1;
                    else if (!pass_reg)
                        state_next = S_PASSB;
                    else
                        state_next = S_SEL;
                end
            end
            S_PASSB:
            begin
                cmd.save_pass = 1'b1;
                cmd.pass_init = 1'b1;
                pass_next     = 1'b1;
                state_next    = S_RD1;
            end
            S_SEL:
            begin
                cmd.push_sel = 1'b1;
                comp_next    = 1'b0;
                state_next   = S_MLO;
            end
            S_MLO:
            begin
                cmd.push_lo = 1'b1;
                state_next  = S_MHI;
            end
            S_MHI:
            begin
                cmd.push_hi = 1'b1;
                state_next  = S_RND;
            end
            S_RND:
            begin
                cmd.push_round = 1'b1;
                if (comp_reg)
                    state_next = S_OUT;
                else
                begin
                    comp_next  = 1'b1;
                    state_next = S_MLO;
                end
            end
            S_OUT:
            begin
                cmd.out_fire   = 1'b1;
                cmd.test_clear = 1'b1;
                state_next     = S_IDLE;
            end
            S_APART:
            begin
                cmd.out_fire   = 1'b1;
                cmd.out_apart  = 1'b1;
                cmd.test_clear = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b0;
            comp_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            comp_reg  <= comp_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> design/sat_dp.sv
// Datapath of the SAT collision unit: vertex stores, normal unit, projector, push.
module sat_dp #(
    parameter int MAX_VERTICES = sat_pkg::SAT_MAX_VERTICES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sat_pkg::sat_in_t   item,
    input  sat_pkg::sat_cmd_t  cmd,
    output sat_pkg::sat_stat_t stat,
    output sat_pkg::sat_out_t  result,
    output logic               done
);
    import sat_pkg::*;

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int C    = SAT_COORD_BITS;
    localparam int EW   = C + 1;
    localparam int NW   = SAT_NORM_BITS;
    localparam int XW   = C + NW;
    localparam int PW   = C + 17;
    localparam int DW   = PW + 2;
    localparam int HALF = (DW + 1) / 2;
    localparam int HI   = DW - HALF;
    localparam int NMW  = NW - 1;
    localparam int PRW  = NMW + DW;
    localparam int MW   = PRW - 27;
    localparam logic [CW-1:0] MAXC = CW'(MAX_VERTICES);
    localparam logic [MW-1:0] LIM  = MW'(1) << (C - 1);

    // vertex stores and counts
    sat_vtx_t          mem_a [MAX_VERTICES];
    sat_vtx_t          mem_b [MAX_VERTICES];
    sat_vtx_t          a_q_reg, b_q_reg, rd_vtx, in_vtx;
    logic              sel_q_reg;
    logic [CW-1:0]     count_a_reg, count_b_reg, a_base;
    logic              a_closed_reg;
    logic              wr_a, wr_b;
    logic [AW-1:0]     rd_addr;
    logic              rd_sel;

    // edge / normal unit
    logic [AW-1:0]     i_reg;
    logic [CW-1:0]     src_cnt, oth_cnt;
    logic              edge_last;
    sat_vtx_t          p1_reg;
    logic signed [EW-1:0] ex, ey;
    logic [EW-1:0]     ex_abs, ey_abs, mx;
    logic [EW-1:0]     ux_reg, uy_reg;
    logic              sx_reg, sy_reg;
    logic [39:0]       sqx_reg, sqy_reg;
    logic [41:0]       v_reg;
    logic [20:0]       root_reg;
    logic [22:0]       srem_reg;
    logic [24:0]       srem_sh, strial;
    logic [35:0]       numx_reg, numy_reg;
    logic [21:0]       dvs_reg;
    logic [22:0]       drx_reg, dry_reg, rshx, rshy;
    logic [15:0]       qx_reg, qy_reg;
    logic signed [NW-1:0] nx_reg, ny_reg;

    // projector
    logic [AW-1:0]     j_reg;
    logic              span_reg;
    logic [CW-1:0]     cur_cnt;
    logic              j_last;
    logic              v1_reg, v2_reg, f1_reg, f2_reg, s1_reg, s2_reg;
    logic signed [C-1:0]  rx, ry;
    logic signed [XW-1:0] px_reg, py_reg;
    logic signed [PW-1:0] t_sum;
    logic signed [PW-1:0] min0_reg, max0_reg, min1_reg, max1_reg;
    logic signed [PW:0]   dif;
    logic signed [DW-1:0] dext, dd;
    logic [DW-1:0]        dmag;

    // best axis per pass
    logic [DW-1:0]        best_mag_reg, mag1_reg;
    logic signed [DW-1:0] best_d_reg, d1_reg, fd;
    logic signed [NW-1:0] bnx_reg, bny_reg, n1x_reg, n1y_reg;
    logic                 sel1;

    // push unit
    logic [DW-1:0]        dm_reg;
    logic                 dneg_reg;
    logic signed [NW-1:0] fnx_reg, fny_reg, nsel;
    logic [NMW-1:0]       nm;
    logic [NMW+HALF-1:0]  plo;
    logic [NMW+HI-1:0]    phi;
    logic [PRW-1:0]       acc_reg;
    logic [PRW:0]         rsum;
    logic [MW-1:0]        mrnd, msat;
    logic                 pneg;
    logic signed [C-1:0]  pval, pushx_reg, pushy_reg;
    sat_out_t             result_reg;
    logic                 done_reg;

    // ---------------- loading ----------------
    assign in_vtx.x = item.vertex_x;
    assign in_vtx.y = item.vertex_y;
    assign a_base   = a_closed_reg ? '0 : count_a_reg;
    assign wr_a     = cmd.load && !item.which_polygon && (a_base < MAXC);
    assign wr_b     = cmd.load && item.which_polygon && (count_b_reg < MAXC);

    always_ff @(posedge clk)
    begin
        if (wr_a)
            mem_a[a_base[AW-1:0]] <= in_vtx;
        if (wr_b)
            mem_b[count_b_reg[AW-1:0]] <= in_vtx;
        a_q_reg   <= mem_a[rd_addr];
        b_q_reg   <= mem_b[rd_addr];
        sel_q_reg <= rd_sel;
    end

    assign rd_vtx = sel_q_reg ? b_q_reg : a_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg  <= '0;
            count_b_reg  <= '0;
            a_closed_reg <= 1'b0;
        end
        else if (cmd.test_clear)
        begin
            count_a_reg  <= '0;
            count_b_reg  <= '0;
            a_closed_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (!item.which_polygon)
            begin
                count_a_reg  <= wr_a ? a_base + 1'b1 : a_base;
                a_closed_reg <= item.last_vertex;
            end
            else if (wr_b)
                count_b_reg <= count_b_reg + 1'b1;
        end
    end

    // ---------------- read addressing ----------------
    assign src_cnt   = cmd.pass_b ? count_b_reg : count_a_reg;
    assign oth_cnt   = cmd.pass_b ? count_a_reg : count_b_reg;
    assign edge_last = (CW'(i_reg) + 1'b1) == src_cnt;
    assign cur_cnt   = span_reg ? oth_cnt : src_cnt;
    assign j_last    = (CW'(j_reg) + 1'b1) == cur_cnt;

    always_comb
    begin
        rd_addr = i_reg;
        rd_sel  = cmd.pass_b;
        if (cmd.edge_rd1)
            rd_addr = i_reg;
        else if (cmd.edge_rd2)
            rd_addr = edge_last ? '0 : i_reg + 1'b1;
        else if (cmd.proj_rd)
        begin
            rd_addr = j_reg;
            rd_sel  = span_reg ^ cmd.pass_b;
        end
    end

    // ---------------- edge and unit normal ----------------
    assign ex     = $signed({p1_reg.y[C-1], p1_reg.y}) - $signed({rd_vtx.y[C-1], rd_vtx.y});
    assign ey     = $signed({rd_vtx.x[C-1], rd_vtx.x}) - $signed({p1_reg.x[C-1], p1_reg.x});
    assign ex_abs = ex[EW-1] ? (~ex + 1'b1) : ex;
    assign ey_abs = ey[EW-1] ? (~ey + 1'b1) : ey;
    assign mx     = (ux_reg > uy_reg) ? ux_reg : uy_reg;

    // restoring square root, two radicand bits per step
    assign srem_sh = {srem_reg, v_reg[41:40]};
    assign strial  = {2'b00, root_reg, 2'b01};
    // long division, one numerator bit per step
    assign rshx    = {drx_reg[21:0], numx_reg[35]};
    assign rshy    = {dry_reg[21:0], numy_reg[35]};

    always_ff @(posedge clk)
    begin
        if (cmd.edge_rd2)
            p1_reg <= rd_vtx;
        if (cmd.edge_load)
        begin
            ux_reg <= ex_abs;
            uy_reg <= ey_abs;
            sx_reg <= ex[EW-1];
            sy_reg <= ey[EW-1];
        end
        else if (cmd.norm_step)
        begin
            if (|mx[EW-1:20])
            begin
                ux_reg <= ux_reg >> 1;
                uy_reg <= uy_reg >> 1;
            end
            else
            begin
                ux_reg <= ux_reg << 1;
                uy_reg <= uy_reg << 1;
            end
        end
        if (cmd.square)
        begin
            sqx_reg <= ux_reg[19:0] * ux_reg[19:0];
            sqy_reg <= uy_reg[19:0] * uy_reg[19:0];
        end
        if (cmd.sqrt_init)
        begin
            v_reg    <= {1'b0, 41'(sqx_reg) + 41'(sqy_reg)};
            root_reg <= '0;
            srem_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            v_reg <= v_reg << 2;
            if (srem_sh >= strial)
            begin
                srem_reg <= 23'(srem_sh - strial);
                root_reg <= {root_reg[19:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_sh[22:0];
                root_reg <= {root_reg[19:0], 1'b0};
            end
        end
        if (cmd.div_init)
        begin
            numx_reg <= {1'b0, ux_reg[19:0], 15'b0} + 36'(root_reg);
            numy_reg <= {1'b0, uy_reg[19:0], 15'b0} + 36'(root_reg);
            dvs_reg  <= {root_reg, 1'b0};
            drx_reg  <= '0;
            dry_reg  <= '0;
            qx_reg   <= '0;
            qy_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            numx_reg <= numx_reg << 1;
            numy_reg <= numy_reg << 1;
            if (rshx >= {1'b0, dvs_reg})
            begin
                drx_reg <= rshx - {1'b0, dvs_reg};
                qx_reg  <= {qx_reg[14:0], 1'b1};
            end
            else
            begin
                drx_reg <= rshx;
                qx_reg  <= {qx_reg[14:0], 1'b0};
            end
            if (rshy >= {1'b0, dvs_reg})
            begin
                dry_reg <= rshy - {1'b0, dvs_reg};
                qy_reg  <= {qy_reg[14:0], 1'b1};
            end
            else
            begin
                dry_reg <= rshy;
                qy_reg  <= {qy_reg[14:0], 1'b0};
            end
        end
        if (cmd.zero_normal)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
        end
        else if (cmd.div_done)
        begin
            nx_reg <= sx_reg ? -$signed(qx_reg) : $signed(qx_reg);
            ny_reg <= sy_reg ? -$signed(qy_reg) : $signed(qy_reg);
        end
    end

    // ---------------- projection sweep ----------------
    assign rx    = rd_vtx.x;
    assign ry    = rd_vtx.y;
    assign t_sum = $signed({px_reg[XW-1], px_reg}) + $signed({py_reg[XW-1], py_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.proj_rd;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pass_init)
            i_reg <= '0;
        else if (cmd.check)
            i_reg <= i_reg + 1'b1;
        if (cmd.proj_start)
        begin
            j_reg    <= '0;
            span_reg <= 1'b0;
        end
        else if (cmd.proj_rd && !(span_reg && j_last))
        begin
            if (j_last)
            begin
                j_reg    <= '0;
                span_reg <= 1'b1;
            end
            else
                j_reg <= j_reg + 1'b1;
        end
        f1_reg <= (j_reg == '0);
        s1_reg <= span_reg;
        f2_reg <= f1_reg;
        s2_reg <= s1_reg;
        px_reg <= nx_reg * rx;
        py_reg <= ny_reg * ry;
        if (v2_reg)
        begin
            if (!s2_reg)
            begin
                if (f2_reg || t_sum < min0_reg)
                    min0_reg <= t_sum;
                if (f2_reg || t_sum > max0_reg)
                    max0_reg <= t_sum;
            end
            else
            begin
                if (f2_reg || t_sum < min1_reg)
                    min1_reg <= t_sum;
                if (f2_reg || t_sum > max1_reg)
                    max1_reg <= t_sum;
            end
        end
    end

    // ---------------- overlap and best axis ----------------
    assign dif  = $signed({min0_reg[PW-1], min0_reg}) - $signed({max1_reg[PW-1], max1_reg});
    assign dext = $signed({dif[PW], dif});
    assign dd   = cmd.pass_b ? -dext : dext;
    assign dmag = dd[DW-1] ? DW'(-dd) : DW'(dd);
    assign sel1 = mag1_reg < best_mag_reg;
    assign fd   = sel1 ? d1_reg : best_d_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.save_pass)
        begin
            mag1_reg <= best_mag_reg;
            d1_reg   <= best_d_reg;
            n1x_reg  <= bnx_reg;
            n1y_reg  <= bny_reg;
        end
        if (cmd.pass_init)
        begin
            best_mag_reg <= '1;
            best_d_reg   <= '0;
            bnx_reg      <= '0;
            bny_reg      <= '0;
        end
        else if (cmd.check && dmag < best_mag_reg)
        begin
            best_mag_reg <= dmag;
            best_d_reg   <= dd;
            bnx_reg      <= nx_reg;
            bny_reg      <= ny_reg;
        end
    end

    // ---------------- push vector ----------------
    assign nsel = cmd.push_comp ? fny_reg : fnx_reg;
    assign nm   = nsel[NW-1] ? NMW'(-nsel) : nsel[NMW-1:0];
    assign plo  = nm * dm_reg[HALF-1:0];
    assign phi  = nm * dm_reg[DW-1:HALF];
    assign rsum = {1'b0, acc_reg} + ((PRW + 1)'(1) << 27);
    assign mrnd = rsum[PRW:28];
    assign pneg = nsel[NW-1] ^ dneg_reg;

    always_comb
    begin
        if (pneg)
        begin
            msat = (mrnd > LIM) ? LIM : mrnd;
            pval = $signed(C'(0) - msat[C-1:0]);
        end
        else
        begin
            msat = (mrnd > LIM - 1'b1) ? LIM - 1'b1 : mrnd;
            pval = $signed(msat[C-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_sel)
        begin
            dm_reg   <= fd[DW-1] ? DW'(-fd) : DW'(fd);
            dneg_reg <= fd[DW-1];
            fnx_reg  <= sel1 ? n1x_reg : bnx_reg;
            fny_reg  <= sel1 ? n1y_reg : bny_reg;
        end
        if (cmd.push_lo)
            acc_reg <= PRW'(plo);
        else if (cmd.push_hi)
            acc_reg <= acc_reg + (PRW'(phi) << HALF);
        if (cmd.push_round)
        begin
            if (cmd.push_comp)
                pushy_reg <= pval;
            else
                pushx_reg <= pval;
        end
        if (cmd.out_fire)
        begin
            result_reg.collides <= !cmd.out_apart;
            result_reg.push_x   <= cmd.out_apart ? '0 : pushx_reg;
            result_reg.push_y   <= cmd.out_apart ? '0 : pushy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.out_fire;
    end

    // ---------------- status ----------------
    assign stat.a_empty   = (count_a_reg == '0);
    assign stat.edge_zero = (mx == '0);
    assign stat.norm_ok   = !(|mx[EW-1:20]) && mx[19];
    assign stat.proj_last = span_reg && j_last;
    assign stat.separated = (min0_reg > max1_reg) || (min1_reg > max0_reg);
    assign stat.edge_last = edge_last;

    assign result = result_reg;
    assign done   = done_reg;

endmodule

>>> design/polygon_sat_collision_unit.sv
// Top level of the 2-D convex polygon collision unit (separating axis test).
//
// Usage: vertices go in one per transfer on item, taken when start is high
// and busy is low. Vertices of polygon A (which_polygon=0) come first, then
// those of B; the B vertex with last_vertex set starts the test and raises
// busy. Vertex transfers that do not close B never raise busy and may come
// back to back. Up to MAX_VERTICES vertices per polygon are kept, more dropped.
// The result appears on result with done high for exactly one cycle; the
// receiver cannot stall it, and busy falls in the same cycle, so the next
// vertex may be offered while done is high.
// Each edge of A, then each edge of B, gets a normal from a fetch, a shift
// search, a square root and a division (the last three skipped on a zero-length
// edge), then a projection sweep over both polygons through the single-read-port
// stores and the overlap check; the test ends early on a gap.
// Reset clears the vertex counts and the sequencer; the stores hold no
// reset and are only read below the counts.
module polygon_sat_collision_unit #(
    parameter int MAX_VERTICES = sat_pkg::SAT_MAX_VERTICES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sat_pkg::sat_in_t  item,
    output logic              busy,
    output logic              done,
    output sat_pkg::sat_out_t result
);
    import sat_pkg::*;

    sat_cmd_t  cmd;
    sat_stat_t stat;

    sat_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .which_polygon (item.which_polygon),
        .last_vertex   (item.last_vertex),
        .stat          (stat),
        .cmd           (cmd),
        .busy          (busy)
    );

    sat_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result),
        .done   (done)
    );

endmodule

>>> design/sat_checker.sv
// Port-level checker of the collision unit and its bind to the top level.
`include "polygon_sat_collision_unit_assert.svh"

module sat_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input sat_pkg::sat_in_t  item,
    input logic              busy,
    input logic              done,
    input sat_pkg::sat_out_t result
);
    `SAT_ASSERT_IMP(a_done_not_busy, done, !busy)
    `SAT_ASSERT_NXT(a_done_single, done, !done)
    `SAT_ASSERT_IMP(a_apart_zero_push, done && !result.collides, result.push_x == 0 && result.push_y == 0)
    `SAT_ASSERT_NXT(a_close_starts, start && !busy && item.which_polygon && item.last_vertex, busy)
    `SAT_ASSERT_IMP(a_end_gives_result, $fell(busy), done)
endmodule

bind polygon_sat_collision_unit sat_checker u_sat_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
);
